// ===== src/uer_pkg.sv =====
// Shared types and constants of the two-sensor ultrasonic echo ranger.
package uer_pkg;

    localparam int PERIOD_W        = 20;
    localparam int TRIG_W          = 10;
    localparam int HS_W            = 10;
    localparam int M_W             = 11;
    localparam int UM_W            = 20;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 20;
    localparam int COUNT_WIDTH_DEF = 20;

    localparam logic [PERIOD_W-1:0] PERIOD_RST     = PERIOD_W'(400000);
    localparam logic [TRIG_W-1:0]   TRIGGER_RST    = TRIG_W'(11);
    localparam logic [HS_W-1:0]     HALF_SPEED_RST = HS_W'(170);

    // One million is 2^6 * 15625: the power-of-two part is a plain shift.
    localparam int DIV_SHIFT    = 6;
    localparam int REM_DIV      = 15625;
    localparam int REM_DIV_LOG2 = 14;
    localparam int REM_W        = 14;

    localparam logic [M_W-1:0]  M_MAX  = M_W'(2047);
    localparam logic [UM_W-1:0] UM_MAX = UM_W'(999999);

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SPEED = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_TRIGGER   = 2'd1,
        PH_WAIT_RISE = 2'd2,
        PH_WAIT_FALL = 2'd3
    } t_phase;

    typedef struct packed {
        logic trigger_first;
        logic trigger_second;
        logic reading_valid;
        logic reading_sensor;
    } t_flags;

endpackage

// ===== src/uer_if.sv =====
// Handshake channels of the echo ranger: echo input, configuration and readings.
interface uer_in_if;
    logic valid;
    logic ready;
    logic echo_first;
    logic echo_second;

    modport source (output valid, output echo_first, output echo_second, input ready);
    modport sink (input valid, input echo_first, input echo_second, output ready);
endinterface

interface uer_cfg_if;
    import uer_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface uer_out_if;
    import uer_pkg::*;
    logic            valid;
    logic            ready;
    logic            trigger_first;
    logic            trigger_second;
    logic            reading_valid;
    logic            reading_sensor;
    logic [M_W-1:0]  distance_m;
    logic [UM_W-1:0] distance_um;

    modport source (
        output valid, output trigger_first, output trigger_second, output reading_valid,
        output reading_sensor, output distance_m, output distance_um, input ready
    );
    modport sink (
        input valid, input trigger_first, input trigger_second, input reading_valid,
        input reading_sensor, input distance_m, input distance_um, output ready
    );
endinterface

// ===== src/ultrasonic_echo_ranger.sv =====
// Two-sensor ultrasonic echo ranger: one result per tick. Throughput is one tick per cycle
// while the output is not stalled; the period/phase state updates on each input transfer,
// and the distance math follows in three pipelined multiplier stages.
// Every stage holds its item while the next one is full, so bubbles absorb output stalls.
// Reset (synchronous, active low) clears all control state and restores register defaults.
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    uer_in_if.sink     i_echo,
    uer_cfg_if.sink    i_cfg,
    uer_out_if.source  o_reading
);

    localparam int PROD_W  = COUNT_WIDTH + HS_W;
    localparam int SH_W    = PROD_W - DIV_SHIFT;
    localparam int K_SHIFT = SH_W + REM_DIV_LOG2;
    localparam int RECIP_W = K_SHIFT - 13;
    localparam int QW      = SH_W - 13;
    localparam int CMP_W   = (QW > M_W) ? QW : M_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << K_SHIFT) + 64'(REM_DIV) - 64'd1) / 64'(REM_DIV));
    localparam logic [COUNT_WIDTH-1:0] WIDTH_MAX = '1;

    // Configuration registers
    logic [PERIOD_W-1:0] r_period_us;
    logic [TRIG_W-1:0]   r_trigger_us;
    logic [HS_W-1:0]     r_half_speed;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_us  <= PERIOD_RST;
            r_trigger_us <= TRIGGER_RST;
            r_half_speed <= HALF_SPEED_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PERIOD:     r_period_us  <= i_cfg.data[PERIOD_W-1:0];
                CFG_TRIGGER:    r_trigger_us <= i_cfg.data[TRIG_W-1:0];
                CFG_HALF_SPEED: r_half_speed <= i_cfg.data[HS_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline stage occupancy and advance
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;
    logic in_xfer;

    assign en4     = !r_v4 || o_reading.ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign i_echo.ready = en1;
    assign in_xfer = i_echo.valid && en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_echo.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Ranging state
    logic [PERIOD_W-1:0]    r_period_count, n_period_count;
    logic                   r_active, n_active;
    t_phase                 r_phase, n_phase;
    logic [TRIG_W-1:0]      r_pulse_count, n_pulse_count;
    logic [COUNT_WIDTH-1:0] r_echo_width, n_echo_width;
    logic                   r_last_echo, n_last_echo;
    t_flags                 n_flags;

    always_comb begin
        logic [PERIOD_W:0] pc_inc;
        logic              echo;
        logic [TRIG_W-1:0] pulse_inc;

        pc_inc         = {1'b0, r_period_count} + (PERIOD_W+1)'(1);
        n_period_count = r_period_count;
        n_active       = r_active;
        n_phase        = r_phase;
        n_pulse_count  = r_pulse_count;
        n_echo_width   = r_echo_width;
        n_flags        = '0;

        // The period end switches sensors and starts the trigger on this same tick.
        if (pc_inc >= {1'b0, r_period_us}) begin
            n_period_count = '0;
            n_active       = !r_active;
            n_phase        = PH_TRIGGER;
            n_pulse_count  = '0;
        end else begin
            n_period_count = pc_inc[PERIOD_W-1:0];
        end

        echo      = n_active ? i_echo.echo_second : i_echo.echo_first;
        pulse_inc = n_pulse_count + TRIG_W'(1);

        unique case (n_phase)
            PH_TRIGGER: begin
                n_flags.trigger_first  = !n_active;
                n_flags.trigger_second = n_active;
                n_pulse_count          = pulse_inc;
                // A zero trigger length still gives a one-tick pulse.
                if (pulse_inc >= r_trigger_us || pulse_inc == '0) begin
                    n_phase = PH_WAIT_RISE;
                end
            end
            PH_WAIT_RISE: begin
                if (echo && !r_last_echo) begin
                    n_phase      = PH_WAIT_FALL;
                    n_echo_width = COUNT_WIDTH'(1);
                end
            end
            PH_WAIT_FALL: begin
                if (echo) begin
                    if (n_echo_width != WIDTH_MAX) begin
                        n_echo_width = n_echo_width + COUNT_WIDTH'(1);
                    end
                end else begin
                    n_flags.reading_valid  = 1'b1;
                    n_flags.reading_sensor = n_active;
                    n_phase                = PH_IDLE;
                end
            end
            default: ;
        endcase

        n_last_echo = echo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_count <= '0;
            r_active       <= 1'b0;
            r_phase        <= PH_IDLE;
            r_pulse_count  <= '0;
            r_echo_width   <= '0;
            r_last_echo    <= 1'b0;
        end else if (in_xfer) begin
            r_period_count <= n_period_count;
            r_active       <= n_active;
            r_phase        <= n_phase;
            r_pulse_count  <= n_pulse_count;
            r_echo_width   <= n_echo_width;
            r_last_echo    <= n_last_echo;
        end
    end

    // Stage 1: flags and the echo width of a completed reading
    t_flags                 r1_flags;
    logic [COUNT_WIDTH-1:0] r1_width;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r1_flags <= n_flags;
            r1_width <= r_echo_width;
        end
    end

    // Stage 2: distance in micrometres
    t_flags            r2_flags;
    logic [PROD_W-1:0] r2_dist;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_flags <= r1_flags;
            r2_dist  <= PROD_W'(r1_width) * PROD_W'(r_half_speed);
        end
    end

    // Stage 3: metres by reciprocal multiply of the distance over 64 by 15625
    localparam int RP_W = SH_W + RECIP_W;

    t_flags                r3_flags;
    logic [QW-1:0]         r3_q;
    logic [SH_W-1:0]       r3_sh;
    logic [DIV_SHIFT-1:0]  r3_low;
    logic [RP_W-1:0]       recip_prod;

    assign recip_prod = RP_W'(r2_dist[PROD_W-1:DIV_SHIFT]) * RP_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_flags <= r2_flags;
            r3_q     <= recip_prod[K_SHIFT +: QW];
            r3_sh    <= r2_dist[PROD_W-1:DIV_SHIFT];
            r3_low   <= r2_dist[DIV_SHIFT-1:0];
        end
    end

    // Stage 4: remainder, saturation and the output register
    t_flags          r4_flags;
    logic [M_W-1:0]  r4_m;
    logic [UM_W-1:0] r4_um;
    logic [SH_W-1:0] rem_sh;
    logic [M_W-1:0]  m_val;
    logic [UM_W-1:0] um_val;

    assign rem_sh = r3_sh - SH_W'(SH_W'(r3_q) * SH_W'(REM_DIV));

    always_comb begin
        if (CMP_W'(r3_q) > CMP_W'(M_MAX)) begin
            m_val  = M_MAX;
            um_val = UM_MAX;
        end else begin
            m_val  = M_W'(r3_q);
            um_val = {rem_sh[REM_W-1:0], r3_low};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_flags <= r3_flags;
            r4_m     <= r3_flags.reading_valid ? m_val : '0;
            r4_um    <= r3_flags.reading_valid ? um_val : '0;
        end
    end

    assign o_reading.valid          = r_v4;
    assign o_reading.trigger_first  = r4_flags.trigger_first;
    assign o_reading.trigger_second = r4_flags.trigger_second;
    assign o_reading.reading_valid  = r4_flags.reading_valid;
    assign o_reading.reading_sensor = r4_flags.reading_sensor;
    assign o_reading.distance_m     = r4_m;
    assign o_reading.distance_um    = r4_um;

endmodule
